// File: src/lwf_pkg.sv
// Package for the LCD window fill sequencer: codes, byte constants and the
// state / item / result structs shared by the step logic and the top level.
// No dependencies.
`timescale 1ns / 1ps

package lwf_pkg;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_PIXELS = 3'd2;
    localparam logic [2:0] PH_FINAL  = 3'd3;

    localparam logic [7:0] CMD_COLUMN = 8'h2A;
    localparam logic [7:0] CMD_ROW    = 8'h2B;
    localparam logic [7:0] CMD_WRITE  = 8'h2C;

    localparam logic [15:0] DEFAULT_TIMEOUT = 16'd500;
    localparam logic [15:0] TICK_MAX        = 16'hFFFF;

    localparam logic       OP_STEP  = 1'b0;
    localparam logic       OP_START = 1'b1;
    localparam logic       STAT_OK      = 1'b0;
    localparam logic       STAT_TIMEOUT = 1'b1;

    // header byte positions
    localparam logic [3:0] HDR_CMD_COL = 4'd0;
    localparam logic [3:0] HDR_XS_HI   = 4'd1;
    localparam logic [3:0] HDR_XS_LO   = 4'd2;
    localparam logic [3:0] HDR_XE_HI   = 4'd3;
    localparam logic [3:0] HDR_XE_LO   = 4'd4;
    localparam logic [3:0] HDR_CMD_ROW = 4'd5;
    localparam logic [3:0] HDR_YS_HI   = 4'd6;
    localparam logic [3:0] HDR_YS_LO   = 4'd7;
    localparam logic [3:0] HDR_YE_HI   = 4'd8;
    localparam logic [3:0] HDR_YE_LO   = 4'd9;
    localparam logic [3:0] HDR_LAST    = 4'd10;

    typedef struct packed {
        logic [2:0]  phase;
        logic [3:0]  header_index;
        logic [15:0] column_count;
        logic [15:0] row_count;
        logic        low_half_next;
        logic [15:0] elapsed_ticks;
        logic [15:0] x_start;
        logic [15:0] x_end;
        logic [15:0] y_start;
        logic [15:0] y_end;
        logic [15:0] fill_color;
    } t_state;

    typedef struct packed {
        logic        operation;
        logic [15:0] x_start;
        logic [15:0] y_start;
        logic [15:0] x_end;
        logic [15:0] y_end;
        logic [15:0] color;
        logic        link_ready;
        logic        ms_tick;
    } t_item;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] byte_value;
        logic       is_data;
        logic       busy_res;
        logic       done_res;
        logic       status;
    } t_result;

endpackage

// File: src/lwf_step.sv
// Next-state and result logic for one beat of the window fill sequencer.
// Purely combinational; depends on lwf_pkg.
`timescale 1ns / 1ps

module lwf_step import lwf_pkg::*; (
    input  t_state      i_state,
    input  t_item       i_item,
    input  logic [15:0] i_timeout,
    output t_state      o_state,
    output t_result     o_result
);

    t_state      n_st;
    t_result     res;
    logic [15:0] ticks;
    logic [15:0] wspan;
    logic [15:0] hspan;
    logic        empty_rect;

    assign wspan      = i_state.x_end - i_state.x_start;
    assign hspan      = i_state.y_end - i_state.y_start;
    assign empty_rect = (i_state.x_end < i_state.x_start) ||
                        (i_state.y_end < i_state.y_start);
    assign ticks      = (i_item.ms_tick && i_state.elapsed_ticks != TICK_MAX) ?
                        i_state.elapsed_ticks + 16'd1 : i_state.elapsed_ticks;

    always_comb begin
        n_st = i_state;
        res  = '0;
        if (i_state.phase == PH_IDLE) begin
            if (i_item.operation == OP_START) begin
                n_st.x_start       = i_item.x_start;
                n_st.x_end         = i_item.x_end;
                n_st.y_start       = i_item.y_start;
                n_st.y_end         = i_item.y_end;
                n_st.fill_color    = i_item.color;
                n_st.header_index  = '0;
                n_st.column_count  = '0;
                n_st.row_count     = '0;
                n_st.low_half_next = 1'b0;
                n_st.elapsed_ticks = '0;
                n_st.phase         = PH_HEADER;
            end
        end else begin
            n_st.elapsed_ticks = ticks;
            if (!i_item.link_ready) begin
                // not-ready beats are the only place a timeout can fire
                if (ticks >= i_timeout) begin
                    res.done_res = 1'b1;
                    res.status   = STAT_TIMEOUT;
                    n_st.phase   = PH_IDLE;
                end
            end else if (i_state.phase == PH_HEADER) begin
                res.byte_valid = 1'b1;
                res.is_data    = 1'b1;
                unique case (i_state.header_index)
                    HDR_CMD_COL: begin
                        res.byte_value = CMD_COLUMN;
                        res.is_data    = 1'b0;
                    end
                    HDR_XS_HI: res.byte_value = i_state.x_start[15:8];
                    HDR_XS_LO: res.byte_value = i_state.x_start[7:0];
                    HDR_XE_HI: res.byte_value = i_state.x_end[15:8];
                    HDR_XE_LO: res.byte_value = i_state.x_end[7:0];
                    HDR_CMD_ROW: begin
                        res.byte_value = CMD_ROW;
                        res.is_data    = 1'b0;
                    end
                    HDR_YS_HI: res.byte_value = i_state.y_start[15:8];
                    HDR_YS_LO: res.byte_value = i_state.y_start[7:0];
                    HDR_YE_HI: res.byte_value = i_state.y_end[15:8];
                    HDR_YE_LO: res.byte_value = i_state.y_end[7:0];
                    default: begin
                        res.byte_value = CMD_WRITE;
                        res.is_data    = 1'b0;
                    end
                endcase
                if (i_state.header_index >= HDR_LAST) begin
                    n_st.phase        = empty_rect ? PH_FINAL : PH_PIXELS;
                    n_st.header_index = '0;
                end else begin
                    n_st.header_index = i_state.header_index + 4'd1;
                end
            end else if (i_state.phase == PH_PIXELS) begin
                res.byte_valid = 1'b1;
                res.is_data    = 1'b1;
                if (!i_state.low_half_next) begin
                    res.byte_value     = i_state.fill_color[15:8];
                    n_st.low_half_next = 1'b1;
                end else begin
                    res.byte_value     = i_state.fill_color[7:0];
                    n_st.low_half_next = 1'b0;
                    if (i_state.row_count == hspan) begin
                        n_st.row_count = '0;
                        if (i_state.column_count == wspan) begin
                            n_st.phase = PH_FINAL;
                        end else begin
                            n_st.column_count = i_state.column_count + 16'd1;
                        end
                    end else begin
                        n_st.row_count = i_state.row_count + 16'd1;
                    end
                end
            end else begin
                res.done_res = 1'b1;
                res.status   = STAT_OK;
                n_st.phase   = PH_IDLE;
            end
        end
        res.busy_res = (n_st.phase != PH_IDLE);
    end

    assign o_state  = n_st;
    assign o_result = res;

endmodule

// File: src/lcd_window_fill_sequencer.sv
// Top level of the LCD window fill sequencer: state and result registers,
// timeout register and handshakes. Depends on lwf_pkg and lwf_step.
//
//   channel  | direction | handshake                | beat payload
//   in       | input     | i_in_valid / o_in_stall  | operation, rectangle, color, link, tick
//   out      | output    | o_out_valid / i_out_stall| byte, tag, busy, done, status
//   cfg      | input     | i_cfg_valid / o_cfg_ready| timeout_ticks (16 bit)
//
// One input beat per clock while not stalled; each gives one result beat, registered.
// Throughput is set by the single output register: the input stalls only
// while that register holds a result and the output side stalls.
// Reset (synchronous, active low) clears the fill state and loads the
// timeout register with 500. The cfg port is always ready.
`timescale 1ns / 1ps

module lcd_window_fill_sequencer import lwf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [15:0] i_x_start,
    input  logic [15:0] i_y_start,
    input  logic [15:0] i_x_end,
    input  logic [15:0] i_y_end,
    input  logic [15:0] i_color,
    input  logic        i_link_ready,
    input  logic        i_ms_tick,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_byte_valid,
    output logic [7:0]  o_byte_value,
    output logic        o_is_data,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic        o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    t_state      r_state;
    t_state      n_state;
    t_result     r_result;
    t_result     n_result;
    t_item       item;
    logic        r_out_valid;
    logic [15:0] r_timeout;
    logic        in_accept;

    assign item = '{operation:  i_operation,
                    x_start:    i_x_start,
                    y_start:    i_y_start,
                    x_end:      i_x_end,
                    y_end:      i_y_end,
                    color:      i_color,
                    link_ready: i_link_ready,
                    ms_tick:    i_ms_tick};

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    lwf_step u_step (
        .i_state  (r_state),
        .i_item   (item),
        .i_timeout(r_timeout),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
            r_timeout   <= DEFAULT_TIMEOUT;
        end else begin
            if (in_accept) begin
                r_state <= n_state;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    // result payload, loaded with each accepted beat
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_byte_valid = r_result.byte_valid;
    assign o_byte_value = r_result.byte_value;
    assign o_is_data    = r_result.is_data;
    assign o_busy_res   = r_result.busy_res;
    assign o_done_res   = r_result.done_res;
    assign o_status     = r_result.status;

endmodule

// File: src/lwf_checker.sv
// Port-level checks for the window fill sequencer, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module lwf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_byte_valid,
    input logic [7:0] o_byte_value,
    input logic       o_is_data,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic       o_status
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_byte_valid) &&
        $stable(o_byte_value) && $stable(o_is_data) && $stable(o_busy_res) &&
        $stable(o_done_res) && $stable(o_status))
        else $error("result beat changed while stalled");

    a_idle_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_valid |-> o_byte_value == 8'd0 && !o_is_data)
        else $error("byte fields set without a byte");

    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_done_res |-> !o_status)
        else $error("status set without done");

    // a finished fill is no longer busy; a sent byte always belongs to a fill
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res && !o_byte_valid)
        else $error("done beat still busy or sending");

    a_byte_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_valid |-> o_busy_res)
        else $error("byte sent outside a fill");

endmodule

bind lcd_window_fill_sequencer lwf_checker u_lwf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_byte_valid(o_byte_valid),
    .o_byte_value(o_byte_value),
    .o_is_data   (o_is_data),
    .o_busy_res  (o_busy_res),
    .o_done_res  (o_done_res),
    .o_status    (o_status)
);
